/* src/sfd_pkg.sv */
// ----------------------------------------------------------------------------
// sfd_pkg: shared types, constants and helpers of the SBUS frame decoder
// Holds the beat kinds, register indexes, frame layout constants and the
// channel conversion functions.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int unsigned FRAME_BYTES_DEF = 25;
  localparam int unsigned STORE_DEPTH     = 10;
  localparam int unsigned STORE_IDX_W     = $clog2(STORE_DEPTH);
  localparam int unsigned COUNT_W         = 5;
  localparam int unsigned TICKS_W         = 16;
  localparam int unsigned CHAN_W          = 11;
  localparam int unsigned STICK_W         = 11;
  localparam int unsigned SW_W            = 2;
  localparam int unsigned CFG_DATA_W      = 16;
  localparam int unsigned CFG_IDX_W       = 2;

  localparam logic [7:0]         START_BYTE = 8'h0F;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
  localparam logic [TICKS_W-1:0] TICKS_MAX  = '1;

  localparam logic [CHAN_W-1:0] CODE_SW_LOW  = 11'd200;
  localparam logic [CHAN_W-1:0] CODE_SW_MID  = 11'd1000;
  localparam logic [CHAN_W-1:0] CODE_SW_HIGH = 11'd1800;
  localparam logic [SW_W-1:0]   SW_STATE_UP   = 2'd1;
  localparam logic [SW_W-1:0]   SW_STATE_MID  = 2'd2;
  localparam logic [SW_W-1:0]   SW_STATE_DOWN = 2'd3;

  localparam logic [10:0] CENTER_RST  = 11'd1000;
  localparam logic [9:0]  HALF_SPAN_RST = 10'd800;
  localparam logic [7:0]  DEAD_ZONE_RST = 8'd10;
  localparam logic [15:0] TIMEOUT_RST   = 16'd100;

  typedef enum logic [1:0] {
    OP_BYTE      = 2'd0,
    OP_FRAME_END = 2'd1,
    OP_TICK      = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER    = 2'd0,
    REG_HALF_SPAN = 2'd1,
    REG_DEAD_ZONE = 2'd2,
    REG_TIMEOUT   = 2'd3
  } cfg_idx_e;

  // What one processed beat produces.
  typedef struct packed {
    logic frame_ok;
    logic timeout;
  } event_t;

  typedef logic [STORE_DEPTH-1:0][7:0] store_t;

  function automatic logic [SW_W-1:0] switch_state(input logic [CHAN_W-1:0] raw);
    logic [SW_W-1:0] s;
    s = SW_STATE_DOWN;
    if (raw == CODE_SW_LOW) begin
      s = SW_STATE_DOWN;
    end else if (raw == CODE_SW_MID) begin
      s = SW_STATE_MID;
    end else if (raw == CODE_SW_HIGH) begin
      s = SW_STATE_UP;
    end
    return s;
  endfunction

  // Centers a raw channel, applies the dead zone and clamps to +/- half span.
  function automatic logic signed [STICK_W-1:0] stick_value(
    input logic [CHAN_W-1:0] raw,
    input logic [10:0]       center,
    input logic [9:0]        half_span,
    input logic [7:0]        dead_zone
  );
    logic signed [CHAN_W:0] v;
    logic        [CHAN_W:0] mag;
    logic signed [CHAN_W:0] lim;
    v   = $signed({1'b0, raw}) - $signed({1'b0, center});
    mag = v[CHAN_W] ? 12'(-v) : 12'(v);
    lim = $signed({2'b00, half_span});
    if (mag < {4'b0000, dead_zone}) begin
      v = '0;
    end
    if (v > lim) begin
      v = lim;
    end else if (v < -lim) begin
      v = -lim;
    end
    return v[STICK_W-1:0];
  endfunction

endpackage

/* src/sfd_frame_state.sv */
// ----------------------------------------------------------------------------
// sfd_frame_state: frame collection and idle timer
// Stores the first bytes of a frame, counts bytes and ticks, and flags a
// good frame end or a timeout for the beat being processed.
// ----------------------------------------------------------------------------
module sfd_frame_state #(
  parameter int unsigned FRAME_BYTES = sfd_pkg::FRAME_BYTES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  logic [1:0]                      op_i,
  input  logic [7:0]                      byte_i,
  input  logic [sfd_pkg::TICKS_W-1:0]     timeout_ticks_i,
  output sfd_pkg::event_t                 event_o,
  output sfd_pkg::store_t                 store_o
);
  import sfd_pkg::*;

  store_t             store_q;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [TICKS_W-1:0] idle_q, idle_d;
  logic               reported_q, reported_d;
  logic [TICKS_W-1:0] limit;
  logic               store_we;
  event_t             ev;

  assign limit = (timeout_ticks_i == '0) ? TICKS_W'(1) : timeout_ticks_i;

  always_comb begin
    count_d    = count_q;
    idle_d     = idle_q;
    reported_d = reported_q;
    store_we   = 1'b0;
    ev         = '0;
    if (step_i) begin
      unique case (op_i)
        OP_BYTE: begin
          store_we = (count_q < COUNT_W'(STORE_DEPTH));
          if (count_q != COUNT_MAX) begin
            count_d = count_q + COUNT_W'(1);
          end
        end
        OP_FRAME_END: begin
          ev.frame_ok = (count_q == COUNT_W'(FRAME_BYTES)) && (store_q[0] == START_BYTE);
          count_d     = '0;
          idle_d      = '0;
          reported_d  = 1'b0;
        end
        OP_TICK: begin
          if (idle_q != TICKS_MAX) begin
            idle_d = idle_q + TICKS_W'(1);
          end
          if ((idle_d >= limit) && !reported_q) begin
            ev.timeout = 1'b1;
            reported_d = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      idle_q     <= '0;
      reported_q <= 1'b0;
    end else begin
      count_q    <= count_d;
      idle_q     <= idle_d;
      reported_q <= reported_d;
    end
  end

  // The store has no reset; a good frame has written every entry first.
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[count_q[STORE_IDX_W-1:0]] <= byte_i;
    end
  end

  assign event_o = ev;
  assign store_o = store_q;

endmodule

/* src/sfd_out_stage.sv */
// ----------------------------------------------------------------------------
// sfd_out_stage: channel decode and result register
// Unpacks the six channels, converts sticks and switches, and holds the
// result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module sfd_out_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  sfd_pkg::event_t       event_i,
  input  sfd_pkg::store_t       store_i,
  input  logic [10:0]           center_i,
  input  logic [9:0]            half_span_i,
  input  logic [7:0]            dead_zone_i,
  output logic                  ready_o,
  output logic                  valid_o,
  input  logic                  take_i,
  output logic [47:0]           data_o,
  output logic                  online_o
);
  import sfd_pkg::*;

  logic [CHAN_W-1:0] ch [6];
  logic [47:0]       data_d, data_q;
  logic              online_q;
  logic              valid_q, valid_d;
  logic              emit;
  logic [STICK_W-1:0] st [4];

  // Little-endian 11-bit unpack from bytes 1 to 9.
  assign ch[0] = CHAN_W'({store_i[2], store_i[1]});
  assign ch[1] = CHAN_W'({store_i[3], store_i[2]} >> 3);
  assign ch[2] = CHAN_W'({store_i[5], store_i[4], store_i[3]} >> 6);
  assign ch[3] = CHAN_W'({store_i[6], store_i[5]} >> 1);
  assign ch[4] = CHAN_W'({store_i[7], store_i[6]} >> 4);
  assign ch[5] = CHAN_W'({store_i[9], store_i[8], store_i[7]} >> 7);

  for (genvar g = 0; g < 4; g++) begin : g_stick
    assign st[g] = stick_value(ch[g], center_i, half_span_i, dead_zone_i);
  end

  assign emit    = event_i.frame_ok || event_i.timeout;
  assign ready_o = !valid_q || take_i;

  always_comb begin
    if (event_i.frame_ok) begin
      data_d = {switch_state(ch[5]), switch_state(ch[4]), st[3], st[2], st[1], st[0]};
    end else begin
      data_d = {SW_STATE_DOWN, SW_STATE_DOWN, 44'd0};
    end
    valid_d = valid_q;
    if (take_i) begin
      valid_d = 1'b0;
    end
    if (load_i && emit) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && emit) begin
      data_q   <= data_d;
      online_q <= event_i.frame_ok;
    end
  end

  assign valid_o  = valid_q;
  assign data_o   = data_q;
  assign online_o = online_q;

endmodule

/* src/sbus_frame_decoder_top.sv */
// ----------------------------------------------------------------------------
// sbus_frame_decoder_top: SBUS receiver frame decoder
// Input beats carry a received byte, an idle-line frame end or a timer tick
// (kind in s_axis_tuser). A frame end of a 25-byte frame that starts with
// 0x0F yields one result beat with four conditioned stick channels and two
// switch states, online set. After timeout_ticks ticks with no frame end,
// one offline result beat goes out with zero sticks and both switches at 3.
// Other beats give no result.
// An input beat lands in the input register at its accepting edge; the
// result, if any, is loaded into the output register when the beat moves on,
// once that register is free or being emptied, and is then visible on
// m_axis_*. One beat per cycle is taken while the output register is free
// or being emptied in that cycle; it is the only thing that limits the rate.
// When the receiver stalls with a result pending, the input register holds
// its beat and s_axis_tready drops until m_axis_tready returns.
// Reset empties both registers, the byte count and the idle timer, and loads
// the configuration defaults. The user writes registers through cfg_* only
// while no beat is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module sbus_frame_decoder_top #(
  parameter int unsigned FRAME_BYTES = sfd_pkg::FRAME_BYTES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,  // [7:0] data_byte
  input  logic [1:0]                         s_axis_tuser,  // [1:0] op
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [10:0] stick_0, [21:11] stick_1, [32:22] stick_2, [43:33] stick_3,
  // [45:44] switch_a, [47:46] switch_b
  output logic [47:0]                        m_axis_tdata,
  output logic                               m_axis_tuser,  // [0] online
  input  logic                               cfg_we_i,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [sfd_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import sfd_pkg::*;

  logic        in_valid_q;
  logic [1:0]  op_q;
  logic [7:0]  byte_q;
  logic        out_ready;
  logic        advance;
  logic        s_fire;

  logic [10:0] center_q;
  logic [9:0]  half_span_q;
  logic [7:0]  dead_zone_q;
  logic [15:0] timeout_q;

  event_t      ev;
  store_t      store;

  assign advance       = in_valid_q && out_ready;
  assign s_axis_tready = !in_valid_q || out_ready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      op_q   <= s_axis_tuser;
      byte_q <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q    <= CENTER_RST;
      half_span_q <= HALF_SPAN_RST;
      dead_zone_q <= DEAD_ZONE_RST;
      timeout_q   <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CENTER:    center_q    <= cfg_data_i[10:0];
        REG_HALF_SPAN: half_span_q <= cfg_data_i[9:0];
        REG_DEAD_ZONE: dead_zone_q <= cfg_data_i[7:0];
        REG_TIMEOUT:   timeout_q   <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  sfd_frame_state #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_state (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .op_i           (op_q),
    .byte_i         (byte_q),
    .timeout_ticks_i(timeout_q),
    .event_o        (ev),
    .store_o        (store)
  );

  sfd_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance),
    .event_i    (ev),
    .store_i    (store),
    .center_i   (center_q),
    .half_span_i(half_span_q),
    .dead_zone_i(dead_zone_q),
    .ready_o    (out_ready),
    .valid_o    (m_axis_tvalid),
    .take_i     (m_axis_tready),
    .data_o     (m_axis_tdata),
    .online_o   (m_axis_tuser)
  );

endmodule

/* tb/sbus_frame_decoder_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sbus_frame_decoder_checker: result checker for the SBUS frame decoder
// Watches the input, result and register channels. It keeps its own copy of
// the frame, the idle timer and the registers, works out the decoded or
// offline result, if any, of every accepted input beat and compares each
// result beat field by field with the oldest one still waiting.
// ----------------------------------------------------------------------------
module sbus_frame_decoder_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_tvalid_i,
  input  logic                                s_tready_i,
  input  logic [7:0]                          s_tdata_i,  // [7:0] data_byte
  input  logic [1:0]                          s_tuser_i,  // [1:0] op
  input  logic                                m_tvalid_i,
  input  logic                                m_tready_i,
  // [10:0] stick_0, [21:11] stick_1, [32:22] stick_2, [43:33] stick_3,
  // [45:44] switch_a, [47:46] switch_b
  input  logic [47:0]                         m_tdata_i,
  input  logic                                m_tuser_i,  // [0] online
  input  logic                                cfg_we_i,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [sfd_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output int                                  fail_count_o,
  output int                                  pending_o
);
  import sfd_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [3:0][10:0] stick;
    logic [1:0]       sw_left;
    logic [1:0]       sw_right;
    logic             online;
  } rc_result_t;

  logic [7:0]  frame_bytes [STORE_DEPTH];
  logic [4:0]  bytes_seen;
  logic [15:0] ticks_idle;
  logic        offline_sent;
  logic [10:0] center_r;
  logic [9:0]  span_r;
  logic [7:0]  dead_r;
  logic [15:0] timeout_r;
  rc_result_t  rc_results_q [$];
  int          reported;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    reported     = 0;
  end

  function automatic logic [10:0] condition_stick(input logic [10:0] raw);
    int v;
    int lim;
    v   = int'(raw) - int'(center_r);
    lim = int'(span_r);
    if ((v < 0 ? -v : v) < int'(dead_r)) begin
      v = 0;
    end
    if (v > lim) begin
      v = lim;
    end
    if (v < -lim) begin
      v = -lim;
    end
    return 11'(v);
  endfunction

  function automatic logic [1:0] decode_switch(input logic [10:0] raw);
    logic [1:0] s;
    case (raw)
      CODE_SW_HIGH: begin
        s = SW_STATE_UP;
      end
      CODE_SW_MID: begin
        s = SW_STATE_MID;
      end
      default: begin
        s = SW_STATE_DOWN;
      end
    endcase
    return s;
  endfunction

  task automatic note_failure(input string msg);
    fail_count_o++;
    if (reported < REPORT_LIMIT) begin
      reported++;
      $display("%0t: mismatch: %s", $realtime, msg);
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      note_failure($sformatf("%s expected %0d, got %0d", name, want, got));
    end
  endtask

  task automatic track_beat(input logic [1:0] kind, input logic [7:0] data);
    logic [71:0] stream;
    rc_result_t  res;
    int          limit;
    case (kind)
      OP_BYTE: begin
        if (bytes_seen < STORE_DEPTH) begin
          frame_bytes[bytes_seen[STORE_IDX_W-1:0]] = data;
        end
        if (bytes_seen != COUNT_MAX) begin
          bytes_seen = bytes_seen + 5'd1;
        end
      end
      OP_FRAME_END: begin
        if (bytes_seen == FRAME_BYTES_DEF && frame_bytes[0] == START_BYTE) begin
          // Channels sit in bytes 1..9 as one little-endian bit stream.
          stream = {frame_bytes[9], frame_bytes[8], frame_bytes[7], frame_bytes[6],
                    frame_bytes[5], frame_bytes[4], frame_bytes[3], frame_bytes[2],
                    frame_bytes[1]};
          for (int i = 0; i < 4; i++) begin
            res.stick[i] = condition_stick(stream[11*i +: 11]);
          end
          res.sw_left  = decode_switch(stream[44 +: 11]);
          res.sw_right = decode_switch(stream[55 +: 11]);
          res.online   = 1'b1;
          rc_results_q.push_back(res);
        end
        bytes_seen   = '0;
        ticks_idle   = '0;
        offline_sent = 1'b0;
      end
      OP_TICK: begin
        limit = (timeout_r == 16'd0) ? 1 : int'(timeout_r);
        if (ticks_idle != TICKS_MAX) begin
          ticks_idle = ticks_idle + 16'd1;
        end
        if (int'(ticks_idle) >= limit && !offline_sent) begin
          offline_sent = 1'b1;
          res.stick    = '0;
          res.sw_left  = SW_STATE_DOWN;
          res.sw_right = SW_STATE_DOWN;
          res.online   = 1'b0;
          rc_results_q.push_back(res);
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_result();
    rc_result_t want;
    if (rc_results_q.size() == 0) begin
      note_failure("result beat with no decoded frame or timeout waiting");
    end else begin
      want = rc_results_q.pop_front();
      for (int i = 0; i < 4; i++) begin
        check_field($sformatf("stick_%0d", i), $signed(want.stick[i]),
                    $signed(m_tdata_i[11*i +: 11]));
      end
      check_field("switch_a", want.sw_left, m_tdata_i[45:44]);
      check_field("switch_b", want.sw_right, m_tdata_i[47:46]);
      check_field("online", want.online, m_tuser_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        frame_bytes[i] = '0;
      end
      bytes_seen   = '0;
      ticks_idle   = '0;
      offline_sent = 1'b0;
      center_r     = CENTER_RST;
      span_r       = HALF_SPAN_RST;
      dead_r       = DEAD_ZONE_RST;
      timeout_r    = TIMEOUT_RST;
      rc_results_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CENTER: begin
            center_r = cfg_data_i[10:0];
          end
          REG_HALF_SPAN: begin
            span_r = cfg_data_i[9:0];
          end
          REG_DEAD_ZONE: begin
            dead_r = cfg_data_i[7:0];
          end
          default: begin
            timeout_r = cfg_data_i[15:0];
          end
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        track_beat(s_tuser_i, s_tdata_i);
      end
      if (m_tvalid_i && m_tready_i) begin
        check_result();
      end
    end
    pending_o = rc_results_q.size();
  end

endmodule

/* tb/tb_sbus_frame_decoder_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sbus_frame_decoder_top: testbench of the SBUS frame decoder
// Drives byte, frame end and tick beats: a few directed cases, then random
// well-formed frames mixed with broken frames, tick bursts and unused beats,
// over several register settings and sender/receiver idling patterns. A
// separate checker predicts and compares the results.
// ----------------------------------------------------------------------------
module tb_sbus_frame_decoder_top;
  import sfd_pkg::*;

  localparam int             WATCHDOG_LIMIT = 4000;
  localparam int             RANDOM_ITEMS   = 1950;
  localparam int             PHASES         = 8;
  localparam int             LATENCY_SLACK  = 4;
  localparam int             END_WAIT       = 20;
  localparam logic [1:0]     OP_UNUSED      = 2'd3;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata;
  logic [1:0]            s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [47:0]           m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int fail_count;
  int pending;
  int quiet_cycles;
  int items_sent;
  int sender_idle_pct;
  int stall_pct;
  int cur_center;
  int cur_span;
  int cur_dead;

  sbus_frame_decoder_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  sbus_frame_decoder_checker frame_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tuser_i    (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= (int'($urandom_range(99)) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[sbus_frame_decoder_top] ERROR");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  // Valid stays high from one beat to the next unless the sender idles.
  task automatic send_beat(input logic [1:0] kind, input logic [7:0] data);
    while (int'($urandom_range(99)) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= data;
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
    if (kind != OP_UNUSED) begin
      items_sent++;
    end
  endtask

  // Bytes 1..9 carry the six channels; bytes from byte 10 on are filler.
  task automatic send_frame(input int len, input logic [7:0] first,
                            input logic [5:0][10:0] chans);
    logic [71:0] stream;
    logic [7:0]  data;
    stream = {6'($urandom), chans};
    for (int k = 0; k < len; k++) begin
      if (k == 0) begin
        data = first;
      end else if (k < 10) begin
        data = stream[8*(k-1) +: 8];
      end else begin
        data = 8'($urandom);
      end
      if ($urandom_range(99) < 8) begin
        send_beat(OP_TICK, 8'($urandom));
      end
      if ($urandom_range(99) < 2) begin
        send_beat(OP_UNUSED, 8'($urandom));
      end
      send_beat(OP_BYTE, data);
    end
    send_beat(OP_FRAME_END, 8'($urandom));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) begin
      @(negedge clk_i);
    end
    repeat (LATENCY_SLACK) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= 16'(value);
    @(negedge clk_i);
  endtask

  task automatic write_config(input int center, input int span, input int dead,
                              input int timeout);
    cur_center  = center;
    cur_span    = span;
    cur_dead    = dead;
    write_reg(REG_CENTER, center);
    write_reg(REG_HALF_SPAN, span);
    write_reg(REG_DEAD_ZONE, dead);
    write_reg(REG_TIMEOUT, timeout);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Sticks land anywhere, at 0 or 2047, near the center and the dead zone edges, or near the clamp edges.
  function automatic logic [10:0] pick_stick();
    int v;
    case ($urandom_range(5))
      0: v = int'($urandom_range(2047));
      1: v = cur_center + int'($urandom_range(2 * cur_dead + 2)) - cur_dead - 1;
      2: v = cur_center + cur_span + int'($urandom_range(4)) - 2;
      3: v = cur_center - cur_span + int'($urandom_range(4)) - 2;
      4: v = 0;
      default: v = 2047;
    endcase
    if (v < 0) begin
      v = 0;
    end
    if (v > 2047) begin
      v = 2047;
    end
    return 11'(v);
  endfunction

  function automatic logic [10:0] pick_switch();
    logic [10:0] raw;
    case ($urandom_range(5))
      0: raw = CODE_SW_LOW;
      1: raw = CODE_SW_MID;
      2: raw = CODE_SW_HIGH;
      3: raw = CODE_SW_MID + 11'd1;
      4: raw = CODE_SW_HIGH - 11'd1;
      default: raw = 11'($urandom);
    endcase
    return raw;
  endfunction

  function automatic logic [5:0][10:0] pick_channels();
    logic [5:0][10:0] chans;
    for (int i = 0; i < 4; i++) begin
      chans[i] = pick_stick();
    end
    chans[4] = pick_switch();
    chans[5] = pick_switch();
    return chans;
  endfunction

  task automatic run_directed();
    logic [5:0][10:0] chans;
    // A zero timeout acts like one tick.
    write_config(1000, 800, 10, 0);
    send_beat(OP_TICK, 8'hFF);
    send_beat(OP_TICK, 8'h00);
    send_beat(OP_UNUSED, 8'hFF);
    send_beat(OP_FRAME_END, 8'h00);
    send_beat(OP_TICK, 8'hAA);
    // Both clamp limits, the inside and the edge of the dead zone, two switches.
    chans[0] = 11'd0;
    chans[1] = 11'd2047;
    chans[2] = 11'd1009;
    chans[3] = 11'd990;
    chans[4] = CODE_SW_HIGH;
    chans[5] = CODE_SW_MID;
    send_frame(FRAME_BYTES_DEF, START_BYTE, chans);
    drain();
  endtask

  task automatic run_random_phase(input int phase);
    int         start_count;
    int         len;
    logic [7:0] first;
    case (phase)
      0: write_config(1000, 800, 10, 100);
      1: write_config(0, 1023, 0, 1);
      2: write_config(2047, 1, 255, 3);
      3: write_config(1024, 0, 255, 0);
      5: write_config(992, 512, 32, 65535);
      7: write_config(1000, 800, 10, 7);
      default: begin
        write_config(int'($urandom_range(2047)), int'($urandom_range(1, 1023)),
                     int'($urandom_range(255)), int'($urandom_range(1, 40)));
      end
    endcase
    case (phase % 4)
      0: begin
        sender_idle_pct = 0;
        stall_pct       = 0;
      end
      1: begin
        sender_idle_pct = 83;
        stall_pct       = 0;
      end
      2: begin
        sender_idle_pct = 0;
        stall_pct       = 83;
      end
      default: begin
        sender_idle_pct = 33;
        stall_pct       = 33;
      end
    endcase
    start_count = items_sent;
    while (items_sent - start_count < RANDOM_ITEMS / PHASES) begin
      case ($urandom_range(19))
        0, 1: begin
          // Short or long frames; long ones can go past the count saturation.
          len = $urandom_range(1) ? int'($urandom_range(24)) : int'($urandom_range(26, 60));
          send_frame(len, START_BYTE, pick_channels());
        end
        2: begin
          first = 8'($urandom);
          while (first == START_BYTE) begin
            first = 8'($urandom);
          end
          send_frame(FRAME_BYTES_DEF, first, pick_channels());
        end
        3, 4, 5: begin
          repeat ($urandom_range(1, 40)) send_beat(OP_TICK, 8'($urandom));
        end
        6: begin
          if ($urandom_range(1)) begin
            send_beat(OP_FRAME_END, 8'($urandom));
          end else begin
            send_beat(OP_UNUSED, 8'($urandom));
          end
        end
        default: begin
          send_frame(FRAME_BYTES_DEF, START_BYTE, pick_channels());
        end
      endcase
    end
    drain();
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tuser    = OP_BYTE;
    m_axis_tready   = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = REG_CENTER;
    cfg_data_i      = '0;
    quiet_cycles    = 0;
    items_sent      = 0;
    sender_idle_pct = 0;
    stall_pct       = 0;
    cur_center      = 1000;
    cur_span        = 800;
    cur_dead        = 10;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    run_directed();
    for (int p = 0; p < PHASES; p++) begin
      run_random_phase(p);
    end
    repeat (END_WAIT) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("[sbus_frame_decoder_top] OK");
    end else begin
      $display("[sbus_frame_decoder_top] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
src/sfd_pkg.sv
src/sfd_frame_state.sv
src/sfd_out_stage.sv
src/sbus_frame_decoder_top.sv
tb/sbus_frame_decoder_checker.sv
tb/tb_sbus_frame_decoder_top.sv
